// ----- src/rdc_pkg.sv -----
// Package for the radix digit converter.
// Holds shared constants, the FSM state type and the digit helper functions.
// No dependencies.
`default_nettype none

package rdc_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int MAX_DIGITS_DEF  = 64;

   localparam int IN_VALUE_W = 64;
   localparam int RADIX_W    = 6;
   localparam int DIGIT_W    = 6;
   localparam int CHAR_W     = 7;
   localparam int COUNT_W    = 7;

   // bits of the dividend consumed by the division unit per cycle
   localparam int CHUNK_BITS = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
   localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) res = RADIX_MIN;
      if (r > RADIX_MAX) res = RADIX_MAX;
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (d < DEC_DIGITS) res = ASCII_ZERO + CHAR_W'(d);
      else                res = ASCII_A + CHAR_W'(d - DEC_DIGITS);
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- src/rdc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none

module rdc_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/rdc_div_step.sv -----
// One chunk of long division by the radix: takes the running remainder and
// the next CHUNK_BITS dividend bits, returns the quotient chunk and new remainder.
// Depends on rdc_pkg.
`default_nettype none

module rdc_div_step
   import rdc_pkg::*;
(
   input  wire logic [DIGIT_W-1:0]    rem_i,
   input  wire logic [CHUNK_BITS-1:0] chunk_i,
   input  wire logic [RADIX_W-1:0]    radix_i,
   output logic      [CHUNK_BITS-1:0] quot_o,
   output logic      [DIGIT_W-1:0]    rem_o
);

   logic [DIGIT_W:0]    r;
   logic [CHUNK_BITS-1:0] q;

   // restoring division, one dividend bit per iteration, MSB first;
   // the remainder stays below the radix so it fits in DIGIT_W bits
   always_comb begin
      r = {1'b0, rem_i};
      q = '0;
      for (int i = CHUNK_BITS - 1; i >= 0; i--) begin
         r = {r[DIGIT_W-1:0], chunk_i[i]};
         if (r >= {1'b0, radix_i}) begin
            r    = r - {1'b0, radix_i};
            q[i] = 1'b1;
         end
      end
      quot_o = q;
      rem_o  = r[DIGIT_W-1:0];
   end

endmodule

`default_nettype wire

// ----- src/radix_digit_converter.sv -----
// Top level of the radix digit converter: command-style input, strobed results.
// Depends on rdc_pkg, rdc_div_step and rdc_ram.
//
//   channel   direction  handshake            payload
//   request   in         start / busy         req_value[63:0], req_radix[5:0]
//   response  out        rsp_valid (strobe)   rsp_digit_char, rsp_digit_count,
//                                             rsp_last_digit
//
// Each digit is worked out in the shared long-division unit, eight dividend
// bits per cycle. While a value is converted busy stays high; its digits are
// strobed on consecutive cycles, the last one in the first cycle with busy low.
// Reset is synchronous and clears the sequencer and digit count; the digit
// store holds no reset. The receiver cannot stall: every digit is a transfer
// on the cycle its strobe is high.
`default_nettype none

module radix_digit_converter
   import rdc_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [IN_VALUE_W-1:0] req_value,
   input  wire logic [RADIX_W-1:0]    req_radix,
   output logic                       rsp_valid,
   output logic      [CHAR_W-1:0]     rsp_digit_char,
   output logic      [COUNT_W-1:0]    rsp_digit_count,
   output logic                       rsp_last_digit
);

   // dividend register is padded up to whole chunks
   localparam int STEPS  = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
   localparam int VW_PAD = STEPS * CHUNK_BITS;
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int AW     = $clog2(MAX_DIGITS);
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

   state_type state_ff, state_in;

   logic [VW_PAD-1:0]  val_ff,   val_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [DIGIT_W-1:0] rem_ff,   rem_in;
   logic [STEP_W-1:0]  step_ff,  step_in;
   logic               qnz_ff,   qnz_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [AW-1:0]      ptr_ff,   ptr_in;
   logic               valid_ff, valid_in;
   logic               last_ff,  last_in;

   logic                  accept;
   logic                  last_step;
   logic                  div_done;
   logic [CHUNK_BITS-1:0] quot_chunk;
   logic [DIGIT_W-1:0]    rem_next;
   logic [VW_PAD+CHUNK_BITS-1:0] val_shift;
   logic                  wr_en;
   logic                  rd_en;
   logic [DIGIT_W-1:0]    rd_digit;

   assign accept    = start && !busy;
   assign last_step = (step_ff == STEP_W'(STEPS - 1));
   // stop once the quotient is zero or the store is full
   assign div_done  = last_step &&
                      (!(qnz_ff || (quot_chunk != '0)) ||
                       (count_ff == CNT_W'(MAX_DIGITS - 1)));

   rdc_div_step u_div (
      .rem_i   (rem_ff),
      .chunk_i (val_ff[VW_PAD-1 -: CHUNK_BITS]),
      .radix_i (radix_ff),
      .quot_o  (quot_chunk),
      .rem_o   (rem_next)
   );

   rdc_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (rem_next),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_digit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (ptr_ff == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      busy  = 1'b1;
      wr_en = 1'b0;
      rd_en = 1'b0;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_DIV: wr_en = last_step;
         ST_EMIT: rd_en = 1'b1;
         default: busy = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      val_shift = {val_ff, quot_chunk};
      val_in    = val_ff;
      radix_in  = radix_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      qnz_in    = qnz_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      valid_in  = 1'b0;
      last_in   = 1'b0;

      if (accept) begin
         // load the masked value, clamp the radix, start a fresh run
         val_in   = VW_PAD'(req_value[VALUE_WIDTH-1:0]);
         radix_in = clamp_radix(req_radix);
         rem_in   = '0;
         step_in  = '0;
         qnz_in   = 1'b0;
         count_in = '0;
      end else if (state_ff == ST_DIV) begin
         // shift the quotient chunk in behind the dividend
         val_in = val_shift[VW_PAD-1:0];
         if (last_step) begin
            count_in = count_ff + CNT_W'(1);
            rem_in   = '0;
            step_in  = '0;
            qnz_in   = 1'b0;
            ptr_in   = count_ff[AW-1:0];
         end else begin
            rem_in  = rem_next;
            step_in = step_ff + STEP_W'(1);
            qnz_in  = qnz_ff || (quot_chunk != '0);
         end
      end else if (state_ff == ST_EMIT) begin
         // read most significant digit first, walk down to entry zero
         valid_in = 1'b1;
         last_in  = (ptr_ff == '0);
         if (ptr_ff != '0) ptr_in = ptr_ff - AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      radix_ff <= radix_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      qnz_ff   <= qnz_in;
      ptr_ff   <= ptr_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_digit_char  = digit_ascii(rd_digit);
   assign rsp_digit_count = COUNT_W'(count_ff);
   assign rsp_last_digit  = last_ff;

endmodule

`default_nettype wire

// ----- src/rdc_checker.sv -----
// Port-level checker for radix_digit_converter, bound to the top level.
// Depends on rdc_pkg and radix_digit_converter.
`default_nettype none

module rdc_checker
   import rdc_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic [CHAR_W-1:0]  rsp_digit_char,
   input wire logic [COUNT_W-1:0] rsp_digit_count,
   input wire logic               rsp_last_digit
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after a transfer");

   a_digits_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_digit |=> rsp_valid)
      else $error("gap inside a digit run");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_digit |=> !rsp_valid)
      else $error("strobe after the last digit");

   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_digit |=> $stable(rsp_digit_count))
      else $error("digit count changed within a run");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digit_char >= ASCII_ZERO && rsp_digit_char <= 7'h39) ||
                    (rsp_digit_char >= ASCII_A && rsp_digit_char <= 7'h5A))
      else $error("digit character out of range");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_digit_char  (rsp_digit_char),
   .rsp_digit_count (rsp_digit_count),
   .rsp_last_digit  (rsp_last_digit)
);

`default_nettype wire
